>>> rtl/snor_pkg.sv
// shared types, codes and constants of the spi nor command sequencer
`default_nettype none
package snor_pkg;
    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int PAGE_BITS    = $clog2(PAGE_BYTES);
    localparam int SECTOR_BITS  = $clog2(SECTOR_BYTES);
    localparam int MAX_RES      = 8;
    localparam int RES_IDX_W    = $clog2(MAX_RES);
    localparam int RES_CNT_W    = RES_IDX_W + 1;

    localparam logic [7:0] FL_READ = 8'h03;
    localparam logic [7:0] FL_PP   = 8'h02;
    localparam logic [7:0] FL_SE   = 8'h20;
    localparam logic [7:0] FL_WREN = 8'h06;
    localparam logic [7:0] FL_RDSR = 8'h05;
    localparam logic [7:0] FL_RDID = 8'h9F;

    localparam logic [1:0] CFG_ADDR_BYTES = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd1;
    localparam logic [2:0] ADDR_BYTES_4   = 3'd4;

    typedef enum logic [2:0] {
        OP_READ = 3'd0, OP_PROG_START = 3'd1, OP_PROG_BYTE = 3'd2, OP_ERASE = 3'd3,
        OP_RX_BYTE = 3'd4, OP_TICK = 3'd5, OP_READ_ID = 3'd6, OP_NOP = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        K_TX = 2'd0, K_RX_COUNT = 2'd1, K_HOST = 2'd2, K_DONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_TIMEOUT = 2'd1, ST_MISALIGNED = 2'd2, ST_BUSY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        M_IDLE = 3'd0, M_READ = 3'd1, M_ID = 3'd2, M_PROG = 3'd3,
        M_POLL_PROG = 3'd4, M_POLL_ERASE = 3'd5
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic [24:0] rx_count;
        logic        eof;
        t_status     status;
        logic        last;
    } t_res;

    function automatic t_res mk(t_kind k, logic [7:0] tx, logic [24:0] rx,
                                logic eof, t_status st);
        t_res r;
        r.kind = k;
        r.tx_byte = tx;
        r.rx_count = rx;
        r.eof = eof;
        r.status = st;
        r.last = 1'b0;
        return r;
    endfunction
endpackage
`default_nettype wire

>>> rtl/spi_nor_command_sequencer.sv
// top level of the spi nor command sequencer
`default_nettype none
// channel | direction | handshake              | payload
// request | in        | i_in_valid/o_in_stall  | opcode, address, length, data_byte
// result  | out       | o_out_valid/i_out_stall| kind, tx_byte, rx_count, eof, status, last
// config  | in        | i_cfg_valid/o_cfg_ready| index, data
//
// a request is registered, then decoded combinationally into up to 8 results
// held in a result batch; results leave one per cycle while i_out_stall is low,
// and a request yields 0 to 8 results (a sector erase header with its poll gives the most)
// a new request is taken while the batch drains; it is decoded as the last
// result of the batch leaves. sync active-low reset clears mode and counters
module spi_nor_command_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [31:0] i_address,
    input  wire logic [24:0] i_length,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_tx_byte,
    output logic [24:0]      o_rx_count,
    output logic             o_end_of_frame,
    output logic [1:0]       o_status,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int PAGE_BITS_W = snor_pkg::PAGE_BITS + 1;
    localparam int CNT_W       = snor_pkg::RES_CNT_W;

    // request register
    logic        r_in_valid;
    logic [2:0]  r_op;
    logic [31:0] r_addr;
    logic [24:0] r_len;
    logic [7:0]  r_data;

    // config
    logic [2:0]  r_aw;
    logic [15:0] r_tmo;

    // sequencer state
    snor_pkg::t_mode r_mode, n_mode;
    logic [31:0] r_ca, n_ca;
    logic [24:0] r_rem, n_rem;
    logic [PAGE_BITS_W-1:0] r_psl, n_psl;
    logic [15:0] r_el, n_el;
    logic        r_wait, n_wait;

    // result batch
    snor_pkg::t_res r_res [snor_pkg::MAX_RES];
    snor_pkg::t_res n_res [snor_pkg::MAX_RES];
    logic [snor_pkg::RES_CNT_W-1:0] r_cnt, n_cnt;
    logic [snor_pkg::RES_IDX_W-1:0] r_idx;
    logic r_bvalid;

    logic take, last_take, load;

    assign take      = r_bvalid && !i_out_stall;
    assign last_take = take && ({1'b0, r_idx} == r_cnt - 1'b1);
    assign load      = r_in_valid && (!r_bvalid || last_take);
    assign o_in_stall  = r_in_valid && !load;
    assign o_cfg_ready = 1'b1;

    // decode of one request into the batch and next state
    always_comb begin
        logic polling, busy_req, nb4, do_chunk, do_sector, pfr, endp;
        logic [31:0] ca;
        logic [24:0] rem;
        logic [PAGE_BITS_W-1:0] space;
        logic [7:0] hop;
        logic heof;
        for (int k = 0; k < snor_pkg::MAX_RES; k++) begin
            n_res[k] = snor_pkg::mk(snor_pkg::K_TX, 8'd0, 25'd0, 1'b0, snor_pkg::ST_OK);
        end
        n_cnt = '0;
        n_mode = r_mode;
        n_ca = r_ca;
        n_rem = r_rem;
        n_psl = r_psl;
        n_el = r_el;
        n_wait = r_wait;
        polling = (r_mode == snor_pkg::M_POLL_PROG) || (r_mode == snor_pkg::M_POLL_ERASE);
        nb4 = (r_aw == snor_pkg::ADDR_BYTES_4);
        busy_req = (r_op == snor_pkg::OP_READ || r_op == snor_pkg::OP_PROG_START ||
                    r_op == snor_pkg::OP_ERASE || r_op == snor_pkg::OP_READ_ID) &&
                   (r_mode != snor_pkg::M_IDLE);
        do_chunk = 1'b0;
        do_sector = 1'b0;
        pfr = 1'b0;
        ca = r_ca;
        rem = r_rem;
        space = '0;
        hop = 8'd0;
        heof = 1'b0;
        endp = 1'b0;
        if (busy_req) begin
            n_res[0] = snor_pkg::mk(snor_pkg::K_DONE, 8'd0, 25'd0, 1'b0, snor_pkg::ST_BUSY);
            n_cnt = CNT_W'(1);
        end else begin
            case (r_op)
                snor_pkg::OP_READ: begin
                    n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_TX, snor_pkg::FL_READ,
                                                     25'd0, 1'b0, snor_pkg::ST_OK);
                    n_cnt = n_cnt + 1'b1;
                    if (nb4) begin
                        n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_TX, r_addr[31:24],
                                                         25'd0, 1'b0, snor_pkg::ST_OK);
                        n_cnt = n_cnt + 1'b1;
                    end
                    n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_TX, r_addr[23:16], 25'd0,
                                                     1'b0, snor_pkg::ST_OK);
                    n_cnt = n_cnt + 1'b1;
                    n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_TX, r_addr[15:8], 25'd0,
                                                     1'b0, snor_pkg::ST_OK);
                    n_cnt = n_cnt + 1'b1;
                    n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_TX, r_addr[7:0], 25'd0,
                                                     1'b0, snor_pkg::ST_OK);
                    n_cnt = n_cnt + 1'b1;
                    n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_RX_COUNT, 8'd0, r_len,
                                                     1'b1, snor_pkg::ST_OK);
                    n_cnt = n_cnt + 1'b1;
                    if (r_len == 25'd0) begin
                        n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_DONE, 8'd0, 25'd0,
                                                         1'b0, snor_pkg::ST_OK);
                        n_cnt = n_cnt + 1'b1;
                    end else begin
                        n_rem = r_len;
                        n_mode = snor_pkg::M_READ;
                    end
                end
                snor_pkg::OP_READ_ID: begin
                    n_res[0] = snor_pkg::mk(snor_pkg::K_TX, snor_pkg::FL_RDID, 25'd0, 1'b0,
                                            snor_pkg::ST_OK);
                    n_res[1] = snor_pkg::mk(snor_pkg::K_RX_COUNT, 8'd0, 25'd3, 1'b1,
                                            snor_pkg::ST_OK);
                    n_cnt = CNT_W'(2);
                    n_rem = 25'd3;
                    n_mode = snor_pkg::M_ID;
                end
                snor_pkg::OP_PROG_START: begin
                    if (r_len == 25'd0) begin
                        n_res[0] = snor_pkg::mk(snor_pkg::K_DONE, 8'd0, 25'd0, 1'b0,
                                                snor_pkg::ST_OK);
                        n_cnt = CNT_W'(1);
                    end else begin
                        ca = r_addr;
                        rem = r_len;
                        do_chunk = 1'b1;
                    end
                end
                snor_pkg::OP_ERASE: begin
                    if (r_addr[snor_pkg::SECTOR_BITS-1:0] != '0 ||
                        r_len[snor_pkg::SECTOR_BITS-1:0] != '0) begin
                        n_res[0] = snor_pkg::mk(snor_pkg::K_DONE, 8'd0, 25'd0, 1'b0,
                                                snor_pkg::ST_MISALIGNED);
                        n_cnt = CNT_W'(1);
                    end else if (r_len == 25'd0) begin
                        n_res[0] = snor_pkg::mk(snor_pkg::K_DONE, 8'd0, 25'd0, 1'b0,
                                                snor_pkg::ST_OK);
                        n_cnt = CNT_W'(1);
                    end else begin
                        ca = r_addr;
                        rem = r_len;
                        do_sector = 1'b1;
                    end
                end
                snor_pkg::OP_PROG_BYTE: begin
                    if (r_mode == snor_pkg::M_PROG) begin
                        endp = (r_psl <= 1);
                        n_res[0] = snor_pkg::mk(snor_pkg::K_TX, r_data, 25'd0, endp,
                                                snor_pkg::ST_OK);
                        n_cnt = CNT_W'(1);
                        if (r_psl != '0) n_psl = r_psl - 1'b1;
                        if (r_rem != '0) n_rem = r_rem - 1'b1;
                        n_ca = r_ca + 32'd1;
                        if (endp) begin
                            n_psl = '0;
                            n_el = '0;
                            pfr = 1'b1;
                            n_mode = snor_pkg::M_POLL_PROG;
                        end
                    end
                end
                snor_pkg::OP_RX_BYTE: begin
                    if (r_mode == snor_pkg::M_READ || r_mode == snor_pkg::M_ID) begin
                        n_res[0] = snor_pkg::mk(snor_pkg::K_HOST, r_data, 25'd0, 1'b0,
                                                snor_pkg::ST_OK);
                        n_cnt = CNT_W'(1);
                        if (r_rem != '0) n_rem = r_rem - 1'b1;
                        if (r_rem <= 1) begin
                            n_res[1] = snor_pkg::mk(snor_pkg::K_DONE, 8'd0, 25'd0, 1'b0,
                                                    snor_pkg::ST_OK);
                            n_cnt = CNT_W'(2);
                            n_mode = snor_pkg::M_IDLE;
                        end
                    end else if (polling && r_wait) begin
                        n_wait = 1'b0;
                        if (!r_data[0]) begin
                            if (r_rem == '0) begin
                                n_res[0] = snor_pkg::mk(snor_pkg::K_DONE, 8'd0, 25'd0, 1'b0,
                                                        snor_pkg::ST_OK);
                                n_cnt = CNT_W'(1);
                                n_mode = snor_pkg::M_IDLE;
                            end else if (r_mode == snor_pkg::M_POLL_PROG) begin
                                do_chunk = 1'b1;
                            end else begin
                                do_sector = 1'b1;
                            end
                        end
                    end
                end
                snor_pkg::OP_TICK: begin
                    if (polling && !r_wait) begin
                        if (r_el >= r_tmo) begin
                            n_res[0] = snor_pkg::mk(snor_pkg::K_DONE, 8'd0, 25'd0, 1'b0,
                                                    snor_pkg::ST_TIMEOUT);
                            n_cnt = CNT_W'(1);
                            n_mode = snor_pkg::M_IDLE;
                            n_rem = '0;
                            n_el = '0;
                        end else begin
                            n_el = r_el + 16'd1;
                            pfr = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // write enable frame and page program / sector erase header
        if (do_chunk || do_sector) begin
            hop = do_chunk ? snor_pkg::FL_PP : snor_pkg::FL_SE;
            heof = do_sector;
            n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_TX, snor_pkg::FL_WREN, 25'd0, 1'b1,
                                             snor_pkg::ST_OK);
            n_cnt = n_cnt + 1'b1;
            n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_TX, hop, 25'd0, 1'b0,
                                             snor_pkg::ST_OK);
            n_cnt = n_cnt + 1'b1;
            if (nb4) begin
                n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_TX, ca[31:24], 25'd0, 1'b0,
                                                 snor_pkg::ST_OK);
                n_cnt = n_cnt + 1'b1;
            end
            n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_TX, ca[23:16], 25'd0, 1'b0,
                                             snor_pkg::ST_OK);
            n_cnt = n_cnt + 1'b1;
            n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_TX, ca[15:8], 25'd0, 1'b0,
                                             snor_pkg::ST_OK);
            n_cnt = n_cnt + 1'b1;
            n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_TX, ca[7:0], 25'd0, heof,
                                             snor_pkg::ST_OK);
            n_cnt = n_cnt + 1'b1;
            n_rem = rem;
            n_ca = ca;
        end
        if (do_chunk) begin
            space = PAGE_BITS_W'(snor_pkg::PAGE_BYTES) -
                    {1'b0, ca[snor_pkg::PAGE_BITS-1:0]};
            n_psl = (rem < 25'(space)) ? rem[PAGE_BITS_W-1:0] : space;
            n_mode = snor_pkg::M_PROG;
        end
        if (do_sector) begin
            n_ca = ca + 32'(snor_pkg::SECTOR_BYTES);
            n_rem = (rem >= 25'(snor_pkg::SECTOR_BYTES)) ?
                    rem - 25'(snor_pkg::SECTOR_BYTES) : 25'd0;
            n_el = '0;
            pfr = 1'b1;
            n_mode = snor_pkg::M_POLL_ERASE;
        end
        // read status poll frame
        if (pfr) begin
            n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_TX, snor_pkg::FL_RDSR, 25'd0, 1'b0,
                                             snor_pkg::ST_OK);
            n_cnt = n_cnt + 1'b1;
            n_res[n_cnt[2:0]] = snor_pkg::mk(snor_pkg::K_RX_COUNT, 8'd0, 25'd1, 1'b1,
                                             snor_pkg::ST_OK);
            n_cnt = n_cnt + 1'b1;
            n_wait = 1'b1;
        end
        if (n_cnt != '0) begin
            n_res[3'(n_cnt - 1'b1)].last = 1'b1;
        end
    end

    // request register and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_aw <= 3'd3;
            r_tmo <= 16'd400;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    snor_pkg::CFG_ADDR_BYTES: r_aw <= i_cfg_data[2:0];
                    snor_pkg::CFG_TIMEOUT:    r_tmo <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        if (!o_in_stall && i_in_valid) begin
            r_op <= i_opcode;
            r_addr <= i_address;
            r_len <= i_length;
            r_data <= i_data_byte;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= snor_pkg::M_IDLE;
            r_ca <= '0;
            r_rem <= '0;
            r_psl <= '0;
            r_el <= '0;
            r_wait <= 1'b0;
        end else if (load) begin
            r_mode <= n_mode;
            r_ca <= n_ca;
            r_rem <= n_rem;
            r_psl <= n_psl;
            r_el <= n_el;
            r_wait <= n_wait;
        end
    end

    // result batch drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= 1'b0;
            r_idx <= '0;
            r_cnt <= '0;
        end else if (load) begin
            r_bvalid <= (n_cnt != '0);
            r_idx <= '0;
            r_cnt <= n_cnt;
        end else if (take) begin
            if (last_take) begin
                r_bvalid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (load) begin
            r_res <= n_res;
        end
    end

    // output drive
    always_comb begin
        o_out_valid    = r_bvalid;
        o_kind         = r_res[r_idx].kind;
        o_tx_byte      = r_res[r_idx].tx_byte;
        o_rx_count     = r_res[r_idx].rx_count;
        o_end_of_frame = r_res[r_idx].eof;
        o_status       = r_res[r_idx].status;
        o_last         = r_res[r_idx].last;
    end

    a_batch_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bvalid |-> (r_cnt != '0 && r_cnt <= snor_pkg::MAX_RES))
        else $error("result batch count out of range");
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bvalid |-> ({1'b0, r_idx} < r_cnt))
        else $error("result index past batch");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_bvalid))
        else $error("stall without pending work");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && o_last) |=> !r_bvalid || $past(load))
        else $error("batch continued after last result");
endmodule
`default_nettype wire

>>> tb/snor_checker.sv
// checker for the spi nor command sequencer: predicts results from accepted requests
`default_nettype none
module snor_checker
    import snor_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [31:0] i_address,
    input  wire logic [24:0] i_length,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_tx_byte,
    input  wire logic [24:0] i_rx_count,
    input  wire logic        i_end_of_frame,
    input  wire logic [1:0]  i_status,
    input  wire logic        i_last,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // sequencer copy: registers and state
    logic [2:0]  addr_bytes_reg;
    logic [15:0] timeout_reg;
    t_mode       seq_mode;
    logic [31:0] prog_addr;
    logic [24:0] remaining;
    logic [8:0]  page_left;
    logic [15:0] elapsed;
    logic        await_status;

    t_res expected_results[$];

    task automatic report(string what, t_res got, t_res want);
        o_errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    function automatic void add(t_kind k, logic [7:0] tx, logic [24:0] rx, logic eof,
                                t_status st);
        t_res r;
        r.kind = k;
        r.tx_byte = tx;
        r.rx_count = rx;
        r.eof = eof;
        r.status = st;
        r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    // opcode then address, msb first
    function automatic void add_header(logic [7:0] cmd, logic [31:0] addr, logic eof);
        int nb;
        nb = (addr_bytes_reg == ADDR_BYTES_4) ? 4 : 3;
        add(K_TX, cmd, '0, 1'b0, ST_OK);
        for (int i = nb - 1; i >= 0; i--)
            add(K_TX, addr[8*i +: 8], '0, (i == 0) ? eof : 1'b0, ST_OK);
    endfunction

    function automatic void add_status_poll();
        add(K_TX, FL_RDSR, '0, 1'b0, ST_OK);
        add(K_RX_COUNT, '0, 25'd1, 1'b1, ST_OK);
        await_status = 1'b1;
    endfunction

    function automatic void begin_page_chunk();
        logic [8:0] space;
        space = 9'(PAGE_BYTES) - 9'(prog_addr[PAGE_BITS-1:0]);
        add(K_TX, FL_WREN, '0, 1'b1, ST_OK);
        add_header(FL_PP, prog_addr, 1'b0);
        page_left = (remaining < 25'(space)) ? remaining[8:0] : space;
        seq_mode = M_PROG;
    endfunction

    function automatic void begin_sector();
        add(K_TX, FL_WREN, '0, 1'b1, ST_OK);
        add_header(FL_SE, prog_addr, 1'b1);
        prog_addr += 32'(SECTOR_BYTES);
        remaining = (remaining >= 25'(SECTOR_BYTES)) ? remaining - 25'(SECTOR_BYTES) : '0;
        elapsed = '0;
        add_status_poll();
        seq_mode = M_POLL_ERASE;
    endfunction

    function automatic void predict_request(t_op op, logic [31:0] addr, logic [24:0] len,
                                            logic [7:0] data);
        int first;
        logic polling;
        logic chunk_end;
        first = expected_results.size();
        polling = (seq_mode == M_POLL_PROG) || (seq_mode == M_POLL_ERASE);
        if ((op == OP_READ || op == OP_PROG_START || op == OP_ERASE || op == OP_READ_ID)
                && seq_mode != M_IDLE) begin
            add(K_DONE, '0, '0, 1'b0, ST_BUSY);
        end else begin
            case (op)
                OP_READ: begin
                    add_header(FL_READ, addr, 1'b0);
                    add(K_RX_COUNT, '0, len, 1'b1, ST_OK);
                    if (len == 0) begin
                        add(K_DONE, '0, '0, 1'b0, ST_OK);
                    end else begin
                        remaining = len;
                        seq_mode = M_READ;
                    end
                end
                OP_READ_ID: begin
                    add(K_TX, FL_RDID, '0, 1'b0, ST_OK);
                    add(K_RX_COUNT, '0, 25'd3, 1'b1, ST_OK);
                    remaining = 25'd3;
                    seq_mode = M_ID;
                end
                OP_PROG_START: begin
                    if (len == 0) begin
                        add(K_DONE, '0, '0, 1'b0, ST_OK);
                    end else begin
                        prog_addr = addr;
                        remaining = len;
                        begin_page_chunk();
                    end
                end
                OP_ERASE: begin
                    if (addr[SECTOR_BITS-1:0] != 0 || len[SECTOR_BITS-1:0] != 0) begin
                        add(K_DONE, '0, '0, 1'b0, ST_MISALIGNED);
                    end else if (len == 0) begin
                        add(K_DONE, '0, '0, 1'b0, ST_OK);
                    end else begin
                        prog_addr = addr;
                        remaining = len;
                        begin_sector();
                    end
                end
                OP_PROG_BYTE: begin
                    if (seq_mode == M_PROG) begin
                        chunk_end = (page_left <= 1);
                        add(K_TX, data, '0, chunk_end, ST_OK);
                        if (page_left > 0) page_left--;
                        if (remaining > 0) remaining--;
                        prog_addr += 32'd1;
                        if (chunk_end) begin
                            page_left = '0;
                            elapsed = '0;
                            add_status_poll();
                            seq_mode = M_POLL_PROG;
                        end
                    end
                end
                OP_RX_BYTE: begin
                    if (seq_mode == M_READ || seq_mode == M_ID) begin
                        add(K_HOST, data, '0, 1'b0, ST_OK);
                        if (remaining > 0) remaining--;
                        if (remaining == 0) begin
                            add(K_DONE, '0, '0, 1'b0, ST_OK);
                            seq_mode = M_IDLE;
                        end
                    end else if (polling && await_status) begin
                        await_status = 1'b0;
                        if (!data[0]) begin
                            if (remaining == 0) begin
                                add(K_DONE, '0, '0, 1'b0, ST_OK);
                                seq_mode = M_IDLE;
                            end else if (seq_mode == M_POLL_PROG) begin
                                begin_page_chunk();
                            end else begin
                                begin_sector();
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (polling && !await_status) begin
                        if (elapsed >= timeout_reg) begin
                            add(K_DONE, '0, '0, 1'b0, ST_TIMEOUT);
                            seq_mode = M_IDLE;
                            remaining = '0;
                            elapsed = '0;
                        end else begin
                            elapsed++;
                            add_status_poll();
                        end
                    end
                end
                default: ;
            endcase
        end
        if (expected_results.size() > first)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    initial begin
        o_errors = 0;
        addr_bytes_reg = 3'd3;
        timeout_reg = 16'd400;
        seq_mode = M_IDLE;
        prog_addr = '0;
        remaining = '0;
        page_left = '0;
        elapsed = '0;
        await_status = 1'b0;
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ADDR_BYTES) addr_bytes_reg = i_cfg_data[2:0];
                else if (i_cfg_index == CFG_TIMEOUT) timeout_reg = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                got.kind = t_kind'(i_kind);
                got.tx_byte = i_tx_byte;
                got.rx_count = i_rx_count;
                got.eof = i_end_of_frame;
                got.status = t_status'(i_status);
                got.last = i_last;
                if (expected_results.size() == 0) begin
                    report("unexpected result", got, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind != want.kind) report("kind", got, want);
                    if (got.tx_byte != want.tx_byte) report("tx_byte", got, want);
                    if (got.rx_count != want.rx_count) report("rx_count", got, want);
                    if (got.eof != want.eof) report("end_of_frame", got, want);
                    if (got.status != want.status) report("status", got, want);
                    if (got.last != want.last) report("last", got, want);
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_request(t_op'(i_opcode), i_address, i_length, i_data_byte);
        end
    end
endmodule
`default_nettype wire

>>> tb/tb_spi_nor_command_sequencer.sv
// testbench top of the spi nor command sequencer: stimulus, idling and verdict
`default_nettype none
module tb_spi_nor_command_sequencer;
    timeunit 1ns;
    timeprecision 1ps;
    import snor_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_opcode;
    logic [31:0] i_address;
    logic [24:0] i_length;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_tx_byte;
    logic [24:0] o_rx_count;
    logic        o_end_of_frame;
    logic [1:0]  o_status;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    int  fail_count;
    int  pending_results;
    int  requests_sent;
    // no idling once set, for the closing stretch of the run
    bit  steady;
    // asks the result side for one long hold-off
    bit  hold_results;

    spi_nor_command_sequencer i_dut (.*);

    snor_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_opcode(i_opcode),
        .i_address(i_address), .i_length(i_length), .i_data_byte(i_data_byte),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_kind(o_kind),
        .i_tx_byte(o_tx_byte), .i_rx_count(o_rx_count), .i_end_of_frame(o_end_of_frame),
        .i_status(o_status), .i_last(o_last),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_errors(fail_count), .o_pending(pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // generous cap on the whole run
    initial begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                // long hold so the batch fills and the request side stalls
                i_out_stall <= 1'b1;
                n = 0;
                while (n < 300) begin
                    @(posedge i_clk);
                    n++;
                end
                i_out_stall <= 1'b0;
                hold_results = 0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // one request; valid stays up across back-to-back requests
    task automatic send_request(t_op op, logic [31:0] addr, logic [24:0] len,
                                logic [7:0] data);
        if (!steady && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_address <= addr;
        i_length <= len;
        i_data_byte <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic go_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // status answers: some busy with a tick after each, then ready
    task automatic answer_polls(int busy_count);
        repeat (busy_count) begin
            send_request(OP_RX_BYTE, $urandom, 25'($urandom), 8'($urandom) | 8'h01);
            send_request(OP_TICK, $urandom, 25'($urandom), 8'($urandom));
        end
        send_request(OP_RX_BYTE, $urandom, 25'($urandom), 8'($urandom) & 8'hFE);
    endtask

    task automatic rx_bytes(int n);
        repeat (n) send_request(OP_RX_BYTE, $urandom, 25'($urandom), 8'($urandom));
    endtask

    // program with data, answering the status poll at every page end and after the last byte
    task automatic program_run(logic [31:0] addr, logic [24:0] len, int max_busy);
        logic [31:0] a;
        send_request(OP_PROG_START, addr, len, 8'($urandom));
        a = addr;
        for (int i = 0; i < int'(len); i++) begin
            send_request(OP_PROG_BYTE, $urandom, 25'($urandom), 8'($urandom));
            a++;
            if (a[PAGE_BITS-1:0] == 0 || i == int'(len) - 1)
                answer_polls($urandom_range(0, max_busy));
        end
    endtask

    task automatic erase_run(logic [31:0] addr, int sectors, int max_busy);
        send_request(OP_ERASE, addr, 25'(sectors * SECTOR_BYTES), 8'($urandom));
        repeat (sectors) answer_polls($urandom_range(0, max_busy));
    endtask

    // drives any leftover request toward its end before a register write
    task automatic drain_sequencer();
        repeat (3) begin
            send_request(OP_PROG_BYTE, $urandom, 25'($urandom), 8'($urandom));
            send_request(OP_RX_BYTE, $urandom, 25'($urandom), 8'h00);
            send_request(OP_TICK, $urandom, 25'($urandom), 8'($urandom));
        end
        go_quiet();
        while (pending_results != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_traffic(int count, int max_busy);
        int stop;
        int pick;
        logic [31:0] a;
        stop = requests_sent + count;
        while (requests_sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                send_request(OP_READ, $urandom, 25'($urandom_range(0, 6)), 8'($urandom));
                rx_bytes($urandom_range(0, 7));
            end else if (pick < 32) begin
                send_request(OP_READ_ID, $urandom, 25'($urandom), 8'($urandom));
                rx_bytes($urandom_range(2, 4));
            end else if (pick < 60) begin
                // start near a page end so chunks split often
                a = $urandom;
                if ($urandom_range(0, 1)) a[PAGE_BITS-1:0] = 8'($urandom_range(240, 255));
                program_run(a, 25'($urandom_range(1, 20)), max_busy);
            end else if (pick < 75) begin
                a = $urandom;
                a[SECTOR_BITS-1:0] = '0;
                erase_run(a, $urandom_range(1, 2), max_busy);
            end else if (pick < 82) begin
                // misaligned erase address or length, or empty program
                case ($urandom_range(0, 2))
                    0: send_request(OP_ERASE, $urandom | 32'h1, 25'h1000, 8'($urandom));
                    1: send_request(OP_ERASE, 32'h1000, 25'($urandom) | 25'h1, 8'($urandom));
                    default: send_request(OP_PROG_START, $urandom, '0, 8'($urandom));
                endcase
            end else begin
                send_request(t_op'($urandom_range(0, 7)), $urandom, 25'($urandom),
                             8'($urandom));
            end
        end
    endtask

    initial begin
        fail_count = 0;
        requests_sent = 0;
        steady = 0;
        hold_results = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_opcode = OP_NOP;
        i_address = '0;
        i_length = '0;
        i_data_byte = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ADDR_BYTES;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, field extremes and the special cases
        send_request(OP_READ, 32'hFFFF_FFFF, 25'd1, 8'h00);
        send_request(OP_READ, 32'hFFFF_FFFF, 25'd1, 8'h00);   // request while busy
        send_request(OP_RX_BYTE, '0, '0, 8'hFF);
        send_request(OP_READ, 32'h0000_0000, 25'd0, 8'h00);   // zero-length read
        send_request(OP_READ_ID, '0, '0, 8'h00);
        rx_bytes(3);
        send_request(OP_PROG_START, 32'h0, 25'd0, 8'h00);     // zero-length program
        send_request(OP_ERASE, 32'h0, 25'd0, 8'h00);          // zero-length erase
        send_request(OP_ERASE, 32'hFFFF_FFFF, 25'h1FF_FFFF, 8'hFF);   // misaligned
        send_request(OP_ERASE, 32'h0000_1000, 25'h100_0001, 8'h00);   // misaligned length
        send_request(OP_PROG_BYTE, '0, '0, 8'h55);            // stray inputs
        send_request(OP_RX_BYTE, '0, '0, 8'h01);
        send_request(OP_TICK, '0, '0, 8'h00);
        send_request(OP_NOP, 32'hFFFF_FFFF, 25'h1FF_FFFF, 8'hFF);
        program_run(32'hFFFF_FFFE, 25'd4, 1);                 // page split and address wrap
        erase_run(32'hFFFF_F000, 2, 2);                       // erase wraps too
        drain_sequencer();

        write_reg(CFG_ADDR_BYTES, 16'd4);
        write_reg(CFG_TIMEOUT, 16'd1);
        program_run(32'h0000_01F8, 25'd16, 4);                // timeouts likely
        random_traffic(15, 4);
        drain_sequencer();

        write_reg(CFG_TIMEOUT, 16'd0);
        write_reg(CFG_ADDR_BYTES, 16'd7);
        random_traffic(15, 2);
        drain_sequencer();

        write_reg(CFG_TIMEOUT, 16'hFFFF);
        write_reg(CFG_ADDR_BYTES, 16'hFFFF);
        program_run(32'h1234_5600, 25'd258, 3);               // a full page and a bit more
        hold_results = 1;
        random_traffic(15, 3);
        drain_sequencer();

        write_reg(CFG_ADDR_BYTES, 16'd0);
        write_reg(CFG_TIMEOUT, 16'd3);
        random_traffic(15, 5);
        drain_sequencer();

        write_reg(CFG_ADDR_BYTES, 16'd4);
        write_reg(CFG_TIMEOUT, 16'd400);
        random_traffic(15, 3);
        steady = 1;
        random_traffic(10, 3);
        go_quiet();

        while (pending_results != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
